>>> sv/lmcf_pkg.sv
package lmcf_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int COUNT_BITS    = 8;
    localparam int FUNC_W        = 2;
    localparam int LETTER_W      = 5;
    localparam int NUMBER_W      = 16;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [FUNC_W-1:0]     func_t;
    typedef logic [LETTER_W-1:0]   letter_t;
    typedef logic [NUMBER_W-1:0]   number_t;

    localparam count_t COUNT_MAX = '1;

    localparam func_t FUNC_REQUIRE   = 2'd0;
    localparam func_t FUNC_CANDIDATE = 2'd1;
    localparam func_t FUNC_CLEAR     = 2'd2;

    typedef struct packed {
        func_t   func;
        letter_t letter;
        logic    has_letter;
        logic    word_end;
        logic    ok;
    } beat_t;

endpackage

>>> sv/lmcf_in_if.sv
interface lmcf_in_if;
    logic                  valid;
    logic                  ready;
    lmcf_pkg::func_t       func;
    lmcf_pkg::letter_t     letter;
    logic                  has_letter;
    logic                  word_end;

    modport source (output valid, output func, output letter, output has_letter,
                    output word_end, input ready);
    modport sink   (input valid, input func, input letter, input has_letter,
                    input word_end, output ready);
endinterface

>>> sv/lmcf_out_if.sv
interface lmcf_out_if;
    logic                  valid;
    logic                  ready;
    logic                  universal;
    lmcf_pkg::number_t     candidate_number;

    modport source (output valid, output universal, output candidate_number, input ready);
    modport sink   (input valid, input universal, input candidate_number, output ready);
endinterface

>>> sv/letter_multiset_containment_filter.sv
// Letter multiset containment filter.
// letters: one beat per letter (func, letter, has_letter, word_end). func 0
//   builds a requirement word, func 1 a candidate word, func 2 clears the
//   requirement table and any partial word; func 3 is ignored.
// results: one beat per candidate word end: universal is 1 when every letter
//   count of the word meets the stored requirement; candidate_number counts
//   candidates from zero and wraps at 16 bits.
// Each beat walks a row of 26 letter cells, one cell per cycle while the next
//   cell has room; each cell holds the working and required count of its
//   letter and checks its count when a candidate word end passes.
// A word_end beat passes each cell register in turn, then the result
//   register, before its result is valid. Throughput: one letter beat
//   per cycle while no stage stalls; every cell stage has its own valid.
// Reset clears all counts, the candidate counter and every stage valid.
// When results stalls, the held result waits in its register; beats keep
//   entering while cell stages have room, and only a candidate word end
//   reaching the result register waits for it to empty.
module letter_multiset_containment_filter (
    input  logic       clk,
    input  logic       rst_n,
    lmcf_in_if.sink    letters,
    lmcf_out_if.source results
);

    logic            stage_valid [0:lmcf_pkg::ALPHABET_SIZE];
    lmcf_pkg::beat_t stage_beat  [0:lmcf_pkg::ALPHABET_SIZE];
    logic            stage_ready [0:lmcf_pkg::ALPHABET_SIZE];

    assign stage_valid[0]           = letters.valid;
    assign stage_beat[0].func       = letters.func;
    assign stage_beat[0].letter     = letters.letter;
    assign stage_beat[0].has_letter = letters.has_letter;
    assign stage_beat[0].word_end   = letters.word_end;
    assign stage_beat[0].ok         = 1'b1;
    assign letters.ready            = stage_ready[0];

    for (genvar i = 0; i < lmcf_pkg::ALPHABET_SIZE; i++)
    begin : g_cell
        lmcf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (lmcf_pkg::letter_t'(i)),
            .up_valid (stage_valid[i]),
            .up_beat  (stage_beat[i]),
            .up_ready (stage_ready[i]),
            .dn_valid (stage_valid[i+1]),
            .dn_beat  (stage_beat[i+1]),
            .dn_ready (stage_ready[i+1])
        );
    end

    lmcf_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid[lmcf_pkg::ALPHABET_SIZE]),
        .up_beat  (stage_beat[lmcf_pkg::ALPHABET_SIZE]),
        .up_ready (stage_ready[lmcf_pkg::ALPHABET_SIZE]),
        .results  (results)
    );

endmodule

>>> sv/lmcf_cell.sv
// One letter slot: holds the working and required count for cell_idx.
module lmcf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  lmcf_pkg::letter_t cell_idx,
    input  logic              up_valid,
    input  lmcf_pkg::beat_t   up_beat,
    output logic              up_ready,
    output logic              dn_valid,
    output lmcf_pkg::beat_t   dn_beat,
    input  logic              dn_ready
);

    logic             valid_reg;
    logic             valid_next;
    lmcf_pkg::beat_t  beat_reg;
    lmcf_pkg::beat_t  beat_next;
    lmcf_pkg::count_t word_reg;
    lmcf_pkg::count_t word_next;
    lmcf_pkg::count_t req_reg;
    lmcf_pkg::count_t req_next;
    lmcf_pkg::count_t word_inc;
    logic             load;
    logic             hit;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;
    assign dn_valid = valid_reg;
    assign dn_beat  = beat_reg;

    assign hit      = up_beat.has_letter && (up_beat.letter == cell_idx)
                      && (word_reg != lmcf_pkg::COUNT_MAX);
    assign word_inc = hit ? word_reg + lmcf_pkg::count_t'(1) : word_reg;

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        beat_next  = up_beat;
        word_next  = word_reg;
        req_next   = req_reg;
        if (load)
        begin
            unique case (up_beat.func)
                lmcf_pkg::FUNC_CLEAR:
                begin
                    word_next = '0;
                    req_next  = '0;
                end
                lmcf_pkg::FUNC_REQUIRE:
                begin
                    if (up_beat.word_end)
                    begin
                        word_next = '0;
                        if (word_inc > req_reg)
                            req_next = word_inc;
                    end
                    else
                        word_next = word_inc;
                end
                lmcf_pkg::FUNC_CANDIDATE:
                begin
                    if (up_beat.word_end)
                    begin
                        word_next    = '0;
                        beat_next.ok = up_beat.ok && (word_inc >= req_reg);
                    end
                    else
                        word_next = word_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            word_reg  <= '0;
            req_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            word_reg  <= word_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            beat_reg <= beat_next;
    end

endmodule

>>> sv/lmcf_out_stage.sv
// Result register: keeps candidate word ends, drops every other beat.
module lmcf_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  lmcf_pkg::beat_t up_beat,
    output logic            up_ready,
    lmcf_out_if.source      results
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              universal_reg;
    lmcf_pkg::number_t number_reg;
    lmcf_pkg::number_t counter_reg;
    lmcf_pkg::number_t counter_next;
    logic              is_result;
    logic              load;

    assign is_result = (up_beat.func == lmcf_pkg::FUNC_CANDIDATE) && up_beat.word_end;
    assign up_ready  = !is_result || !out_valid_reg || results.ready;
    assign load      = up_valid && is_result && up_ready;

    assign out_valid_next = load ? 1'b1 : (results.ready ? 1'b0 : out_valid_reg);
    assign counter_next   = load ? counter_reg + lmcf_pkg::number_t'(1) : counter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            counter_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            counter_reg   <= counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            universal_reg <= up_beat.ok;
            number_reg    <= counter_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.universal        = universal_reg;
    assign results.candidate_number = number_reg;

endmodule
